// ===== rtl/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants of the first-fit segment allocator
// Operation and status codes, default sizes and the controller/datapath link.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int MaxSegmentsDefault = 32;
  localparam int AddrBitsDefault    = 16;
  localparam int OwnerBitsDefault   = 14;

  localparam int KindBits   = 2;
  localparam int StatusBits = 2;

  localparam logic [KindBits-1:0] KIND_ALLOC    = 2'd0;
  localparam logic [KindBits-1:0] KIND_RELEASE  = 2'd1;
  localparam logic [KindBits-1:0] KIND_COALESCE = 2'd2;

  localparam logic [StatusBits-1:0] ST_OK        = 2'd0;
  localparam logic [StatusBits-1:0] ST_NO_FIT    = 2'd1;
  localparam logic [StatusBits-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatusBits-1:0] ST_FULL      = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic init;       // reload table with one free segment
    logic load;       // capture request, clear scan index
    logic scan_next;  // advance scan index
    logic do_alloc;   // claim entry at scan index, split if needed
    logic do_release; // free entry at scan index
    logic merge_start;// restart merge index at zero
    logic merge_step; // merge or advance at merge index
  } ffsa_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_end;   // scan index beyond last valid entry
    logic alloc_hit;  // entry at scan index fits the request
    logic need_split; // hit entry is longer than the request
    logic full;       // table at capacity
    logic rel_hit;    // entry at scan index is owned by requester
    logic merge_end;  // merge index at last valid entry
  } ffsa_stat_t;

endpackage

// ===== rtl/ffsa_datapath.sv =====
// ----------------------------------------------------------------------------
// ffsa_datapath: segment table and scan/shift logic
// Holds the table in a row of registers; each command moves or edits the
// whole row at once (shift by one place), the search walks one entry per
// cycle.
// ----------------------------------------------------------------------------
module ffsa_datapath #(
  parameter int MAX_SEGMENTS = 32,
  parameter int ADDR_BITS    = 16,
  parameter int OWNER_BITS   = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ffsa_pkg::ffsa_cmd_t   cmd,
  output ffsa_pkg::ffsa_stat_t  stat,
  input  logic [ADDR_BITS:0]    mem_size,
  input  logic [OWNER_BITS-1:0] req_owner,
  input  logic [ADDR_BITS:0]    req_size,
  output logic [ADDR_BITS-1:0]  hit_start,
  output logic [ADDR_BITS:0]    hit_length,
  output logic [ADDR_BITS:0]    req_length
);
  import ffsa_pkg::*;

  localparam int IdxBits = $clog2(MAX_SEGMENTS);
  localparam int CntBits = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CntBits-1:0] CntMax = CntBits'(MAX_SEGMENTS);

  logic                  seg_free   [MAX_SEGMENTS];
  logic [OWNER_BITS-1:0] seg_owner  [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0]  seg_start  [MAX_SEGMENTS];
  logic [ADDR_BITS:0]    seg_length [MAX_SEGMENTS];
  logic [CntBits-1:0]    seg_count;
  logic [CntBits-1:0]    scan_idx;
  logic [CntBits-1:0]    merge_idx;
  logic [OWNER_BITS-1:0] owner_q;
  logic [ADDR_BITS:0]    size_q;

  logic [IdxBits-1:0] sp;
  logic [IdxBits-1:0] mp;
  logic               m_pair;

  assign sp = scan_idx[IdxBits-1:0];
  assign mp = merge_idx[IdxBits-1:0];

  assign stat.scan_end   = scan_idx >= seg_count;
  assign stat.alloc_hit  = seg_free[sp] && (seg_length[sp] >= size_q) && (size_q != '0);
  assign stat.need_split = seg_length[sp] != size_q;
  assign stat.full       = seg_count == CntMax;
  assign stat.rel_hit    = !seg_free[sp] && (seg_owner[sp] == owner_q);
  assign stat.merge_end  = (merge_idx + CntBits'(1)) >= seg_count;

  assign m_pair = seg_free[mp] && (mp < IdxBits'(MAX_SEGMENTS - 1))
                  && seg_free[(mp < IdxBits'(MAX_SEGMENTS - 1)) ? mp + IdxBits'(1) : mp];

  assign hit_start  = seg_start[sp];
  assign hit_length = seg_length[sp];
  assign req_length = size_q;

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        seg_free[k]   <= (k == 0);
        seg_owner[k]  <= '0;
        seg_start[k]  <= '0;
        seg_length[k] <= (k == 0) ? (rst ? (ADDR_BITS+1)'(1) << ADDR_BITS : mem_size) : '0;
      end
      seg_count <= CntBits'(1);
      scan_idx  <= '0;
      merge_idx <= '0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        owner_q  <= req_owner;
        size_q   <= req_size;
      end
      if (cmd.scan_next) begin
        scan_idx <= scan_idx + CntBits'(1);
      end
      if (cmd.do_alloc) begin
        // open a slot after the hit entry by shifting the tail up one place
        if (stat.need_split) begin
          for (int k = 1; k < MAX_SEGMENTS; k++) begin
            if (k > int'(sp) + 1) begin
              seg_free[k]   <= seg_free[k-1];
              seg_owner[k]  <= seg_owner[k-1];
              seg_start[k]  <= seg_start[k-1];
              seg_length[k] <= seg_length[k-1];
            end else if (k == int'(sp) + 1) begin
              seg_free[k]   <= 1'b1;
              seg_owner[k]  <= '0;
              seg_start[k]  <= seg_start[sp] + size_q[ADDR_BITS-1:0];
              seg_length[k] <= seg_length[sp] - size_q;
            end
          end
          seg_count <= seg_count + CntBits'(1);
        end
        seg_free[sp]   <= 1'b0;
        seg_owner[sp]  <= owner_q;
        seg_length[sp] <= size_q;
      end
      if (cmd.do_release) begin
        seg_free[sp]  <= 1'b1;
        seg_owner[sp] <= '0;
      end
      if (cmd.merge_start) begin
        merge_idx <= '0;
      end
      if (cmd.merge_step) begin
        if (m_pair) begin
          // fold the next entry in and pull the tail down one place
          seg_length[mp] <= seg_length[mp] + seg_length[mp + IdxBits'(1)];
          for (int k = 1; k < MAX_SEGMENTS; k++) begin
            if (k > int'(mp)) begin
              if (k < MAX_SEGMENTS - 1) begin
                seg_free[k]   <= seg_free[k+1];
                seg_owner[k]  <= seg_owner[k+1];
                seg_start[k]  <= seg_start[k+1];
                seg_length[k] <= seg_length[k+1];
              end else begin
                seg_free[k]   <= 1'b0;
                seg_owner[k]  <= '0;
                seg_start[k]  <= '0;
                seg_length[k] <= '0;
              end
            end
          end
          seg_count <= seg_count - CntBits'(1);
        end else begin
          merge_idx <= merge_idx + CntBits'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/ffsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffsa_ctrl: request sequencer
// Walks the table for a fit or an owner, runs the merge pass after a release
// and for a coalesce, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module ffsa_ctrl #(
  parameter int ADDR_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ffsa_pkg::KindBits-1:0]       kind,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ffsa_pkg::StatusBits-1:0]     status,
  output logic [ADDR_BITS-1:0]                segment_start,
  output logic [ADDR_BITS:0]                  segment_length,
  output ffsa_pkg::ffsa_cmd_t                 cmd,
  input  ffsa_pkg::ffsa_stat_t                stat,
  input  logic [ADDR_BITS-1:0]                hit_start,
  input  logic [ADDR_BITS:0]                  hit_length,
  input  logic [ADDR_BITS:0]                  req_length
);
  import ffsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_RELEASE, S_MERGE, S_DONE
  } state_t;

  state_t state;

  assign in_ready  = (state == S_IDLE) && !cfg_write;
  assign out_valid = (state == S_DONE);

  always_comb begin
    cmd = '0;
    cmd.init = cfg_write;
    case (state)
      S_IDLE: begin
        cmd.load        = in_valid && in_ready;
        cmd.merge_start = in_valid && in_ready;
      end
      S_ALLOC: begin
        if (!stat.scan_end) begin
          if (stat.alloc_hit) begin
            cmd.do_alloc = !(stat.need_split && stat.full);
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      S_RELEASE: begin
        if (!stat.scan_end) begin
          if (stat.rel_hit) begin
            cmd.do_release  = 1'b1;
            cmd.merge_start = 1'b1;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      S_MERGE: begin
        cmd.merge_step = !stat.merge_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            status         <= ST_OK;
            segment_start  <= '0;
            segment_length <= '0;
            case (kind)
              KIND_ALLOC:    state <= S_ALLOC;
              KIND_RELEASE:  state <= S_RELEASE;
              KIND_COALESCE: state <= S_MERGE;
              default:       state <= S_DONE;
            endcase
          end
        end
        S_ALLOC: begin
          if (stat.scan_end) begin
            status <= ST_NO_FIT;
            state  <= S_DONE;
          end else if (stat.alloc_hit) begin
            if (stat.need_split && stat.full) begin
              status <= ST_FULL;
            end else begin
              segment_start  <= hit_start;
              segment_length <= req_length;
            end
            state <= S_DONE;
          end
        end
        S_RELEASE: begin
          if (stat.scan_end) begin
            status <= ST_NOT_FOUND;
            state  <= S_DONE;
          end else if (stat.rel_hit) begin
            segment_start  <= hit_start;
            segment_length <= hit_length;
            state          <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (stat.merge_end) state <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/first_fit_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_segment_allocator: first-fit segment table with merge
// Allocates, releases and coalesces memory segments in address order.
//
//   channel  signals                               direction
//   in       in_valid/in_ready, kind, owner_id,    into block
//            request_size
//   out      out_valid/out_ready, status,          out of block
//            segment_start, segment_length
//   cfg      psel/penable/pwrite/paddr/pwdata      APB, memory_size
//
// One item at a time. An allocate searches the table one entry per cycle;
// a release searches it the same way for the owner, then runs the merge
// pass (at most about 2*MAX_SEGMENTS merge steps); a coalesce runs only
// the merge pass. The table lives in flip-flops and shifts by one place
// on a split or a merge. Reset and a memory_size write reload the table.
// A stalled output beat holds off the next input beat.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDefault,
  parameter int ADDR_BITS    = ffsa_pkg::AddrBitsDefault,
  parameter int OWNER_BITS   = ffsa_pkg::OwnerBitsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [1:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ffsa_pkg::KindBits-1:0]     kind,
  input  logic [OWNER_BITS-1:0]             owner_id,
  input  logic [ADDR_BITS:0]                request_size,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ffsa_pkg::StatusBits-1:0]   status,
  output logic [ADDR_BITS-1:0]              segment_start,
  output logic [ADDR_BITS:0]                segment_length
);
  import ffsa_pkg::*;

  localparam logic [ADDR_BITS:0] MemLimit = (ADDR_BITS+1)'(1) << ADDR_BITS;

  logic [ADDR_BITS:0] memory_size;
  logic [ADDR_BITS:0] size_next;
  logic               cfg_write;
  logic [16:0]        wr_val;
  ffsa_cmd_t          cmd;
  ffsa_stat_t         stat;
  logic [ADDR_BITS-1:0] hit_start;
  logic [ADDR_BITS:0]   hit_length;
  logic [ADDR_BITS:0]   req_length;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == 2'd0);
  assign wr_val    = pwdata[16:0];
  assign prdata    = (paddr == 2'd0) ? 32'(memory_size) : '0;

  // zero becomes one, anything above the address range saturates
  always_comb begin
    if (wr_val == '0) begin
      size_next = (ADDR_BITS+1)'(1);
    end else if (33'(wr_val) > 33'(MemLimit)) begin
      size_next = MemLimit;
    end else begin
      size_next = (ADDR_BITS+1)'(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size <= MemLimit;
    end else if (cfg_write) begin
      memory_size <= size_next;
    end
  end

  ffsa_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_BITS(ADDR_BITS), .OWNER_BITS(OWNER_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .mem_size(size_next), .req_owner(owner_id), .req_size(request_size),
    .hit_start, .hit_length, .req_length
  );

  ffsa_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk, .rst, .cfg_write, .in_valid, .in_ready, .kind,
    .out_valid, .out_ready, .status, .segment_start, .segment_length,
    .cmd, .stat, .hit_start, .hit_length, .req_length
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (segment_length == '0 && segment_start == '0))
    else $error("failed request reports a segment");

  a_alloc_one: assert property (@(posedge clk) disable iff (rst)
    !(cmd.do_alloc && cmd.do_release)) else $error("conflicting table edits");

endmodule
